/* src/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 RGB box blur: payload words,
// pixel and sum types, register map and the divide-by-nine constants.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int PIX_W    = 8;
    localparam int CSUM_W   = 10;
    localparam int WSUM_W   = 12;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 10;

    localparam int CFG_W       = 11;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_BIT = 2;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd800;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd600;

    localparam int MIN_WIDTH  = 3;
    localparam int MIN_HEIGHT = 1;

    // floor(s / 9) == (s * 3641) >> 15 for every s below 32768
    localparam int DIV9_MUL   = 3641;
    localparam int DIV9_MUL_W = 12;
    localparam int DIV9_SHIFT = 15;
    localparam int PROD_W     = WSUM_W + DIV9_MUL_W;

    typedef logic [COL_W-1:0] t_col;
    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } t_csum;

    typedef struct packed {
        logic [WSUM_W-1:0] red;
        logic [WSUM_W-1:0] green;
        logic [WSUM_W-1:0] blue;
    } t_wsum;

    typedef struct packed {
        t_pix upper;
        t_pix lower;
    } t_line_pair;

    typedef struct packed {
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
        logic             is_padding;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        t_col             pixel_column;
        t_row             pixel_row;
        logic             run_last;
    } t_out;

endpackage

/* src/bb3_line_mem.sv */
// ----------------------------------------------------------------------------
// bb3_line_mem
// Single-port-read, single-port-write line memory with registered read data.
// ----------------------------------------------------------------------------
module bb3_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/bb3_div9.sv */
// ----------------------------------------------------------------------------
// bb3_div9
// Divide the three channel window sums by nine, truncating, by reciprocal
// multiplication.
// ----------------------------------------------------------------------------
module bb3_div9 (
    input  bb3_pkg::t_wsum i_sum,
    output bb3_pkg::t_pix  o_pix
);

    logic [bb3_pkg::PROD_W-1:0] prod_red;
    logic [bb3_pkg::PROD_W-1:0] prod_green;
    logic [bb3_pkg::PROD_W-1:0] prod_blue;

    assign prod_red   = bb3_pkg::PROD_W'(i_sum.red)
                      * bb3_pkg::PROD_W'(bb3_pkg::DIV9_MUL);
    assign prod_green = bb3_pkg::PROD_W'(i_sum.green)
                      * bb3_pkg::PROD_W'(bb3_pkg::DIV9_MUL);
    assign prod_blue  = bb3_pkg::PROD_W'(i_sum.blue)
                      * bb3_pkg::PROD_W'(bb3_pkg::DIV9_MUL);

    assign o_pix.red   = prod_red[bb3_pkg::DIV9_SHIFT +: bb3_pkg::PIX_W];
    assign o_pix.green = prod_green[bb3_pkg::DIV9_SHIFT +: bb3_pkg::PIX_W];
    assign o_pix.blue  = prod_blue[bb3_pkg::DIV9_SHIFT +: bb3_pkg::PIX_W];

endmodule

/* src/box_blur_3x3_rgb_top.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top
// 3x3 box blur of an RGB raster stream with two line stores in one memory.
// ----------------------------------------------------------------------------
// Input words carry one pixel each in raster order, followed after every frame
// by one row of padding words that flushes the bottom row. Output words carry
// a blurred pixel (window sum / 9, truncated) with its column and row; the
// last column of a row follows the column before it, both caused by the last
// input word of the next row, run_last marking the last word of one input.
// Both channels use valid/ready. A word is taken every clock while the output
// does not stall; the last word of each row causes two results, so a row of
// width W gives W results, and holds the input back while both are pending.
// A result passes through stage 1, stage 2 and the output register in turn.
// The line stores sit in one memory read at the accepting edge and written
// back one stage later; consecutive words never touch the same column.
// Registers: active_width at 0x0, active_height at 0x4, 11 bits each, used
// clamped to 3..MAX_WIDTH and 1..MAX_HEIGHT; write them only while idle.
// Reset clears position counters, window and pipeline and restores width 800
// and height 600; line memory content stays undefined until written.
// When the receiver stalls, the output word holds and the pipeline fills
// back to the input, where ready drops.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bb3_pkg::PADDR_W-1:0]  paddr,
    input  logic [bb3_pkg::PDATA_W-1:0]  pwdata,
    output logic [bb3_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bb3_pkg::t_in                 i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bb3_pkg::t_out                o_out_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > bb3_pkg::CFG_W) ?
                         $clog2(MAX_WIDTH + 1) : bb3_pkg::CFG_W;
    localparam int HCW = ($clog2(MAX_HEIGHT + 1) > bb3_pkg::CFG_W) ?
                         $clog2(MAX_HEIGHT + 1) : bb3_pkg::CFG_W;
    localparam int LW  = $bits(bb3_pkg::t_line_pair);

    // configuration registers
    logic [bb3_pkg::CFG_W-1:0] r_cfg_width;
    logic [bb3_pkg::CFG_W-1:0] r_cfg_height;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= bb3_pkg::WIDTH_RESET;
            r_cfg_height <= bb3_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[bb3_pkg::REG_IDX_BIT])
                bb3_pkg::REG_WIDTH: begin
                    r_cfg_width <= pwdata[bb3_pkg::CFG_W-1:0];
                end
                bb3_pkg::REG_HEIGHT: begin
                    r_cfg_height <= pwdata[bb3_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[bb3_pkg::REG_IDX_BIT])
            bb3_pkg::REG_WIDTH:  prdata = bb3_pkg::PDATA_W'(r_cfg_width);
            bb3_pkg::REG_HEIGHT: prdata = bb3_pkg::PDATA_W'(r_cfg_height);
            default:             prdata = '0;
        endcase
    end

    // clamped frame size
    logic [WCW-1:0] w_ext;
    logic [HCW-1:0] h_ext;
    logic [XW-1:0]  w_m1;
    logic [YW-1:0]  h;

    assign w_ext = WCW'(r_cfg_width);
    assign h_ext = HCW'(r_cfg_height);

    always_comb begin
        if (w_ext < WCW'(bb3_pkg::MIN_WIDTH)) begin
            w_m1 = XW'(bb3_pkg::MIN_WIDTH - 1);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w_m1 = XW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = XW'(w_ext - WCW'(1));
        end
    end

    always_comb begin
        if (h_ext < HCW'(bb3_pkg::MIN_HEIGHT)) begin
            h = YW'(bb3_pkg::MIN_HEIGHT);
        end else if (h_ext > HCW'(MAX_HEIGHT)) begin
            h = YW'(MAX_HEIGHT);
        end else begin
            h = YW'(h_ext);
        end
    end

    // accept stage
    logic [XW-1:0]  r_col;
    logic [YW-1:0]  r_row;
    logic           in_acc;
    logic           flush;
    logic           row_end;
    logic           produce;
    bb3_pkg::t_pix  bot_in;

    assign in_acc  = i_in_valid & o_in_ready;
    assign flush   = i_in_data.is_padding | (r_row >= h);
    assign row_end = (r_col >= w_m1);
    assign produce = (r_row != '0) & (r_row <= h);

    always_comb begin
        if (flush) begin
            bot_in = '0;
        end else begin
            bot_in.red   = i_in_data.in_red;
            bot_in.green = i_in_data.in_green;
            bot_in.blue  = i_in_data.in_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= (r_row >= h) ? '0 : r_row + YW'(1);
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    // stage 1: line memory data arrives, window update, write back
    logic                r_s1_valid;
    logic [XW-1:0]       r_s1_x;
    bb3_pkg::t_row       r_s1_row;
    bb3_pkg::t_pix       r_s1_bot;
    logic                r_s1_use_top;
    logic                r_s1_use_mid;
    logic                r_s1_first;
    logic                r_s1_pa;
    logic                r_s1_pb;
    logic                s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x       <= r_col;
            r_s1_row     <= bb3_pkg::t_row'(r_row - YW'(1));
            r_s1_bot     <= bot_in;
            r_s1_use_top <= (r_row > YW'(1));
            r_s1_use_mid <= (r_row != '0);
            r_s1_first   <= (r_col == '0);
            r_s1_pa      <= produce & (r_col != '0);
            r_s1_pb      <= produce & row_end;
        end
    end

    logic [LW-1:0]        rd_data;
    bb3_pkg::t_line_pair  rd_pair;
    bb3_pkg::t_line_pair  wr_pair;
    bb3_pkg::t_pix        top;
    bb3_pkg::t_pix        mid;

    assign rd_pair = bb3_pkg::t_line_pair'(rd_data);
    assign top     = r_s1_use_top ? rd_pair.upper : '0;
    assign mid     = r_s1_use_mid ? rd_pair.lower : '0;
    assign wr_pair.upper = mid;
    assign wr_pair.lower = r_s1_bot;

    bb3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW),
        .DW    (LW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_x),
        .i_wr_data (LW'(wr_pair))
    );

    bb3_pkg::t_csum r_cs1;
    bb3_pkg::t_csum r_cs2;
    bb3_pkg::t_csum cs;
    bb3_pkg::t_csum cs1e;
    bb3_pkg::t_csum cs2e;
    bb3_pkg::t_wsum sum_a;
    bb3_pkg::t_wsum sum_b;

    assign cs.red   = bb3_pkg::CSUM_W'(top.red) + bb3_pkg::CSUM_W'(mid.red)
                    + bb3_pkg::CSUM_W'(r_s1_bot.red);
    assign cs.green = bb3_pkg::CSUM_W'(top.green) + bb3_pkg::CSUM_W'(mid.green)
                    + bb3_pkg::CSUM_W'(r_s1_bot.green);
    assign cs.blue  = bb3_pkg::CSUM_W'(top.blue) + bb3_pkg::CSUM_W'(mid.blue)
                    + bb3_pkg::CSUM_W'(r_s1_bot.blue);

    assign cs1e = r_s1_first ? '0 : r_cs1;
    assign cs2e = r_s1_first ? '0 : r_cs2;

    assign sum_b.red   = bb3_pkg::WSUM_W'(cs1e.red) + bb3_pkg::WSUM_W'(cs.red);
    assign sum_b.green = bb3_pkg::WSUM_W'(cs1e.green) + bb3_pkg::WSUM_W'(cs.green);
    assign sum_b.blue  = bb3_pkg::WSUM_W'(cs1e.blue) + bb3_pkg::WSUM_W'(cs.blue);
    assign sum_a.red   = sum_b.red + bb3_pkg::WSUM_W'(cs2e.red);
    assign sum_a.green = sum_b.green + bb3_pkg::WSUM_W'(cs2e.green);
    assign sum_a.blue  = sum_b.blue + bb3_pkg::WSUM_W'(cs2e.blue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs1 <= '0;
            r_cs2 <= '0;
        end else if (s1_adv) begin
            r_cs2 <= cs1e;
            r_cs1 <= cs;
        end
    end

    // stage 2: up to two pending results
    logic            r_s2_pa;
    logic            r_s2_pb;
    bb3_pkg::t_wsum  r_s2_sum_a;
    bb3_pkg::t_wsum  r_s2_sum_b;
    bb3_pkg::t_col   r_s2_col_a;
    bb3_pkg::t_col   r_s2_col_b;
    bb3_pkg::t_row   r_s2_row;
    logic            s2_valid;
    logic            s2_emit;
    logic            s2_free;
    logic            out_take;

    assign s2_valid   = r_s2_pa | r_s2_pb;
    assign s2_emit    = s2_valid & out_take;
    assign s2_free    = ~s2_valid | (out_take & ~(r_s2_pa & r_s2_pb));
    assign s1_adv     = r_s1_valid & s2_free;
    assign o_in_ready = ~r_s1_valid | s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_pa <= 1'b0;
            r_s2_pb <= 1'b0;
        end else if (s1_adv) begin
            r_s2_pa <= r_s1_pa;
            r_s2_pb <= r_s1_pb;
        end else if (s2_emit) begin
            if (r_s2_pa) begin
                r_s2_pa <= 1'b0;
            end else begin
                r_s2_pb <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_sum_a <= sum_a;
            r_s2_sum_b <= sum_b;
            r_s2_col_a <= bb3_pkg::t_col'(r_s1_x - XW'(1));
            r_s2_col_b <= bb3_pkg::t_col'(r_s1_x);
            r_s2_row   <= r_s1_row;
        end
    end

    // output register
    bb3_pkg::t_wsum  sel_sum;
    bb3_pkg::t_pix   quot;
    bb3_pkg::t_out   n_out;
    bb3_pkg::t_out   r_out;
    logic            r_out_valid;

    assign sel_sum = r_s2_pa ? r_s2_sum_a : r_s2_sum_b;

    bb3_div9 u_div9 (
        .i_sum (sel_sum),
        .o_pix (quot)
    );

    assign n_out.out_red      = quot.red;
    assign n_out.out_green    = quot.green;
    assign n_out.out_blue     = quot.blue;
    assign n_out.pixel_column = r_s2_pa ? r_s2_col_a : r_s2_col_b;
    assign n_out.pixel_row    = r_s2_row;
    assign n_out.run_last     = ~(r_s2_pa & r_s2_pb);

    assign out_take = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted word did not reach stage 1");

    a_no_mem_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && in_acc) |-> (r_s1_x != r_col))
        else $error("line memory read and write hit the same column");

    a_first_waits_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.run_last) |-> r_s2_pb)
        else $error("non-final word shown without its follower pending");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_free) |=> (r_s1_valid && $stable(r_s1_x)))
        else $error("stage 1 lost its word while stage 2 was busy");
`endif

endmodule

/* tb/box_blur_3x3_rgb_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top_test
// Self-checking bench for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
// A queue of pixel words is streamed in raster order, frame by frame, each
// frame followed by its flush row. Every accepted input word runs through a
// local blur predictor (line stores, window, position counters and the two
// size registers mirrored from the APB bus) and the blurred words it implies
// are queued. Output words are checked field by field against that queue.
// Stimulus: a short directed part (saturated and zero pixels, padding inside
// a frame, flush rows with and without the padding flag), the size extremes,
// size changes in the middle of a frame, then random frames of small random
// size, some cut short and completed with padding. Both channels stall in
// random bursts, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top_test;

    import bb3_pkg::*;

    localparam int LINE_DEPTH   = 1024;
    localparam int SETTLE_CYC   = 4;
    localparam int RAND_WORDS   = 520;
    localparam int CALM_WORDS   = 440;
    localparam int MAX_REPORTS  = 40;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [PDATA_W-1:0] pwdata       = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    t_in                i_in_data    = '0;
    logic               o_out_valid;
    logic               i_out_ready  = 1'b0;
    t_out               o_out_data;

    box_blur_3x3_rgb_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // predictor state
    t_pix             line_upper [LINE_DEPTH];
    t_pix             line_lower [LINE_DEPTH];
    t_pix             win_cols [6];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_out             blur_q [$];
    t_out             due_word;

    t_in              pix_q [$];
    int unsigned      px_sent_cnt  = 0;
    int unsigned      px_taken_cnt = 0;
    int unsigned      err_cnt      = 0;
    bit               in_fire      = 1'b0;
    bit               calm         = 1'b0;
    int               in_gap       = 0;
    int               out_stall    = 0;
    int               in_gap_pct   = 10;
    int               out_stall_pct = 10;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned eff_width();
        if (width_reg < MIN_WIDTH) return MIN_WIDTH;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < MIN_HEIGHT) return MIN_HEIGHT;
        if (height_reg > LINE_DEPTH) return LINE_DEPTH;
        return height_reg;
    endfunction

    function automatic t_out blur_word(input int n_cols, input t_pix top, input t_pix mid,
                                       input t_pix bot, input int unsigned col,
                                       input int unsigned row, input bit last);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        t_out        o;
        r = top.red;
        g = top.green;
        b = top.blue;
        r += mid.red + bot.red;
        g += mid.green + bot.green;
        b += mid.blue + bot.blue;
        for (int i = 0; i < n_cols; i++) begin
            r += win_cols[i].red;
            g += win_cols[i].green;
            b += win_cols[i].blue;
        end
        o.out_red      = PIX_W'(r / 9);
        o.out_green    = PIX_W'(g / 9);
        o.out_blue     = PIX_W'(b / 9);
        o.pixel_column = COL_W'(col);
        o.pixel_row    = ROW_W'(row);
        o.run_last     = last;
        return o;
    endfunction

    function automatic void blur_predict(input t_in word);
        int unsigned wd;
        int unsigned ht;
        int unsigned x;
        int unsigned y;
        t_pix        top;
        t_pix        mid;
        t_pix        bot;
        bit          row_end;
        bit          produce;
        wd = eff_width();
        ht = eff_height();
        x = col_pos;
        y = row_pos;
        bot = (word.is_padding || y >= ht) ? t_pix'('0)
                                           : {word.in_red, word.in_green, word.in_blue};
        top = '0;
        mid = '0;
        row_end = (x >= wd - 1);
        produce = (y >= 1) && (y <= ht);
        if (y >= 2) top = line_upper[x];
        if (y >= 1) mid = line_lower[x];
        line_upper[x] = mid;
        line_lower[x] = bot;
        if (x == 0) begin
            foreach (win_cols[i]) win_cols[i] = '0;
        end
        if (produce && x >= 1) blur_q.push_back(blur_word(6, top, mid, bot, x - 1, y - 1, !row_end));
        if (produce && row_end) blur_q.push_back(blur_word(3, top, mid, bot, x, y - 1, 1'b1));
        win_cols[3] = win_cols[0];
        win_cols[4] = win_cols[1];
        win_cols[5] = win_cols[2];
        win_cols[0] = top;
        win_cols[1] = mid;
        win_cols[2] = bot;
        if (row_end) begin
            col_pos = 0;
            row_pos = (y >= ht) ? 0 : ((y + 1) & 32'h7FF);
        end else begin
            col_pos = (x + 1) & 32'h3FF;
        end
    endfunction

    function automatic string fmt_word(input t_out o);
        return $sformatf("rgb=%0d/%0d/%0d col=%0d row=%0d last=%0d", o.out_red, o.out_green,
                         o.out_blue, o.pixel_column, o.pixel_row, o.run_last);
    endfunction

    // monitor: register mirror, prediction of accepted words, output check
    always @(posedge i_clk) begin
        in_fire <= i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            foreach (win_cols[i]) win_cols[i] = '0;
            blur_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if ((paddr >> REG_IDX_BIT) == REG_WIDTH) width_reg = pwdata[CFG_W-1:0];
                else if ((paddr >> REG_IDX_BIT) == REG_HEIGHT) height_reg = pwdata[CFG_W-1:0];
            end
            if (i_in_valid && o_in_ready) begin
                blur_predict(i_in_data);
                px_taken_cnt++;
            end
            if (o_out_valid && i_out_ready) begin
                if (blur_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected output word, actual %s", $time,
                                 fmt_word(o_out_data));
                end else begin
                    due_word = blur_q.pop_front();
                    if (o_out_data.out_red !== due_word.out_red
                            || o_out_data.out_green !== due_word.out_green
                            || o_out_data.out_blue !== due_word.out_blue
                            || o_out_data.pixel_column !== due_word.pixel_column
                            || o_out_data.pixel_row !== due_word.pixel_row
                            || o_out_data.run_last !== due_word.run_last) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: output word mismatch, expected %s, actual %s", $time,
                                     fmt_word(due_word), fmt_word(o_out_data));
                    end
                end
            end
        end
    end

    // driver: pixel words and output backpressure
    always @(negedge i_clk) begin
        if (!i_in_valid || in_fire) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!calm && $urandom_range(99) < in_gap_pct) begin
                in_gap <= $urandom_range(18, 0);
                i_in_valid <= 1'b0;
            end else if (pix_q.size() != 0) begin
                i_in_data <= pix_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(99) < out_stall_pct) begin
            out_stall <= $urandom_range(18, 0);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    task automatic push_px(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                           input logic [PIX_W-1:0] b, input logic pad);
        t_in v;
        v.in_red     = r;
        v.in_green   = g;
        v.in_blue    = b;
        v.is_padding = pad;
        pix_q.push_back(v);
        px_sent_cnt++;
    endtask

    task automatic push_items(input int n, input int pad_pct);
        @(posedge i_clk);
        repeat (n) push_px(rand_chan(), rand_chan(), rand_chan(), $urandom_range(99) < pad_pct);
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (px_taken_cnt != px_sent_cnt || blur_q.size() != 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << REG_IDX_BIT;
        pwdata  <= ($urandom() << CFG_W) | PDATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // drain, then pad out the current frame and its flush row
    task automatic finish_frame();
        int unsigned wd;
        int unsigned ht;
        int unsigned rem;
        settle();
        if (col_pos != 0 || row_pos != 0) begin
            wd = eff_width();
            ht = eff_height();
            rem = (col_pos + 1 >= wd) ? 1 : wd - col_pos;
            if (row_pos < ht) rem += (ht - row_pos) * wd;
            push_items(rem, 100);
            settle();
        end
    endtask

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int unsigned      rand_cnt;
        int unsigned      wd;
        int unsigned      ht;
        int unsigned      n;
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        rand_cnt = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // saturated frame; flush row without the padding flag
        set_frame(3, 3);
        @(posedge i_clk);
        repeat (12) push_px('1, '1, '1, 1'b0);
        settle();

        // single row, padding inside the frame, mixed flush flags
        set_frame(4, 0);
        @(posedge i_clk);
        push_px(8'd0, 8'd0, 8'd0, 1'b0);
        push_px(8'd255, 8'd0, 8'd255, 1'b1);
        push_px(8'd1, 8'd2, 8'd3, 1'b0);
        push_px(8'd255, 8'd255, 8'd255, 1'b0);
        push_px(8'd255, 8'd255, 8'd255, 1'b0);
        push_px(8'd9, 8'd9, 8'd9, 1'b1);
        push_px(8'd255, 8'd255, 8'd255, 1'b0);
        push_px(8'd0, 8'd0, 8'd0, 1'b1);
        settle();

        // oversized width register, cut to the minimum inside the first row
        in_gap_pct = 5;
        out_stall_pct = 5;
        set_frame(11'd2047, 11'd0);
        push_items(24, 5);
        settle();
        write_reg(REG_WIDTH, 11'd3);
        finish_frame();

        // oversized height register, cut back after a few rows
        set_frame(11'd0, 11'd2047);
        push_items(15, 3);
        settle();
        write_reg(REG_HEIGHT, 11'd6);
        finish_frame();

        // shrink width and height mid-row: the current row becomes the flush row
        in_gap_pct = pick_pct();
        out_stall_pct = pick_pct();
        set_frame(8, 6);
        push_items(28, 5);
        settle();
        set_frame(3, 3);
        finish_frame();

        // shrink height below the current row: rest of the row gives nothing
        set_frame(4, 5);
        push_items(12, 5);
        settle();
        write_reg(REG_HEIGHT, 1);
        finish_frame();

        while (rand_cnt < RAND_WORDS) begin
            finish_frame();
            if (rand_cnt >= CALM_WORDS) calm = 1'b1;
            in_gap_pct = pick_pct();
            out_stall_pct = pick_pct();
            case ($urandom_range(9))
                0: w_raw = $urandom_range(2);
                1: w_raw = $urandom_range(40, 13);
                default: w_raw = $urandom_range(12, 3);
            endcase
            case ($urandom_range(9))
                0: h_raw = 0;
                1: h_raw = $urandom_range(10, 7);
                default: h_raw = $urandom_range(6, 1);
            endcase
            set_frame(w_raw, h_raw);
            wd = eff_width();
            ht = eff_height();
            repeat ($urandom_range(3, 1)) begin
                if ($urandom_range(7) == 0) begin
                    n = $urandom_range(wd * (ht + 1) - 1, 1);
                    push_items(n, 10);
                    rand_cnt += n;
                end else begin
                    push_items(wd * ht, 4);
                    push_items(wd, 50);
                    rand_cnt += wd * (ht + 1);
                end
            end
        end
        settle();

        if (err_cnt == 0 && blur_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
